// File: hdl/periodic_task_scheduler_macros.svh
// Assertion macros for the periodic task scheduler.
// Used by the top level only; no other dependencies.
`ifndef PERIODIC_TASK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define PTS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define PTS_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: hdl/pts_pkg.sv
// Package for the periodic task scheduler: commands, status codes, slot type.
// No dependencies.
package pts_pkg;
  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_FIRE = 8;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;
  localparam logic [1:0] CMD_DELETE = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [7:0]  handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  runs;
  } slot_t;

  // Per-cycle control that every cell sees.
  typedef struct packed {
    logic load;      // write load data into the cell at the tail
    logic tick;      // age every valid cell
    logic shift;     // cells at or above the shift point take their upper neighbor
    logic dec_runs;  // decrement runs of the head cell
  } cell_ctl_t;
endpackage

// File: hdl/pts_if.sv
// Valid/ready channel interfaces of the periodic task scheduler.
// Depends on nothing.
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  task_handle;
  logic [31:0] start_delay;
  logic [31:0] repeat_period;
  logic [2:0]  slot_to_delete;
  modport source (output valid, command, task_handle, start_delay, repeat_period,
                  slot_to_delete, input ready);
  modport sink (input valid, command, task_handle, start_delay, repeat_period,
                slot_to_delete, output ready);
endinterface

interface pts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] slot_index;
  logic [7:0] due_handle;
  logic       fired;
  logic       last;
  modport source (output valid, status, slot_index, due_handle, fired, last,
                  input ready);
  modport sink (input valid, status, slot_index, due_handle, fired, last,
                output ready);
endinterface

// File: hdl/pts_cell.sv
// One task slot of the scheduler chain; holds a slot and talks to its neighbor.
// Depends on pts_pkg.
module pts_cell import pts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      is_tail,   // this cell is slot task_count
  input  logic      is_head,   // this cell is the slot under dispatch
  input  logic      in_shift,  // this cell is at or above the removal point
  input  slot_t     load_slot,
  input  slot_t     upper,     // neighbor above
  output slot_t     cur
);
  slot_t cur_r, cur_nxt;
  assign cur = cur_r;

  always_comb begin
    cur_nxt = cur_r;
    if (ctl.load && is_tail) begin
      cur_nxt = load_slot;
    end else if (ctl.tick && cur_r.valid) begin
      if (cur_r.delay == 32'd0) begin
        if (cur_r.runs != 8'hFF) cur_nxt.runs = cur_r.runs + 8'd1;
        if (cur_r.period != 32'd0) cur_nxt.delay = cur_r.period;
      end else begin
        cur_nxt.delay = cur_r.delay - 32'd1;
      end
    end else if (ctl.shift && in_shift) begin
      cur_nxt = upper;
    end else if (ctl.dec_runs && is_head) begin
      cur_nxt.runs = cur_r.runs - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end
endmodule

// File: hdl/periodic_task_scheduler.sv
// Periodic task scheduler top level: control sequencer over a chain of slot cells.
// Depends on pts_pkg, pts_if, pts_cell and periodic_task_scheduler_macros.svh.
//
//   channel | dir | contents
//   in      | in  | command, task_handle, start_delay, repeat_period, slot_to_delete
//   out     | out | status, slot_index, due_handle, fired, last
//
// Add, tick and delete act in the accepting cycle; the result is valid the cycle after.
// Dispatch walks from slot 0: it passes over a slot with no pending runs, fires a slot that
// has runs (a fired one-shot task is shifted out), and stops after MAX_FIRE fires or at the
// end of the chain; the closing step registers the last result.
// A fired result waits in a holding register until the next fire or the end of the walk
// decides its last flag. A stalled result holds the walk; one item is in work at a time.
// Reset (synchronous, rst_n low) clears every slot and the task count.
`include "periodic_task_scheduler_macros.svh"
module periodic_task_scheduler import pts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pts_in_if.sink   in_ch,
  pts_out_if.source out_ch
);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int XW = (CW > 3) ? CW : 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // walk position
  logic [3:0]  nfired_r, nfired_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  ostatus_r, ostatus_nxt;
  logic [2:0]  oslot_r, oslot_nxt;
  logic [7:0]  ohandle_r, ohandle_nxt;
  logic        ofired_r, ofired_nxt;
  logic        olast_r, olast_nxt;
  logic        hvalid_r, hvalid_nxt;
  logic [2:0]  hslot_r, hslot_nxt;
  logic [7:0]  hhandle_r, hhandle_nxt;

  cell_ctl_t ctl;
  logic [CW-1:0] shift_pt;
  slot_t load_slot;
  slot_t cells [MAX_TASKS];
  slot_t head;

  assign load_slot = '{valid: 1'b1, handle: in_ch.task_handle, delay: in_ch.start_delay,
                       period: in_ch.repeat_period, runs: 8'd0};
  assign head = (idx_r < CW'(MAX_TASKS)) ? cells[idx_r[IW-1:0]] : '0;

  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cell
      slot_t up;
      if (g == MAX_TASKS - 1) begin : g_top
        assign up = '0;
      end else begin : g_mid
        assign up = cells[g+1];
      end
      pts_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .is_tail(count_r == CW'(g)),
        .is_head(idx_r == CW'(g)),
        .in_shift(CW'(g) >= shift_pt),
        .load_slot(load_slot), .upper(up), .cur(cells[g])
      );
    end
  endgenerate

  logic free_out;
  assign free_out = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && free_out;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  logic walk_done;
  assign walk_done = (idx_r >= count_r) || (nfired_r == 4'(MAX_FIRE));

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; idx_nxt = idx_r; nfired_nxt = nfired_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ostatus_nxt = ostatus_r; oslot_nxt = oslot_r; ohandle_nxt = ohandle_r;
    ofired_nxt = ofired_r; olast_nxt = olast_r;
    hvalid_nxt = hvalid_r; hslot_nxt = hslot_r; hhandle_nxt = hhandle_r;
    ctl = '0; shift_pt = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          ovalid_nxt = 1'b1; ostatus_nxt = ST_OK; oslot_nxt = 3'd0; ohandle_nxt = 8'd0;
          ofired_nxt = 1'b0; olast_nxt = 1'b1;
          case (in_ch.command)
            CMD_ADD: begin
              if (count_r < CW'(MAX_TASKS)) begin
                ctl.load = 1'b1; oslot_nxt = 3'(count_r); count_nxt = count_r + 1'b1;
              end else begin
                ostatus_nxt = ST_FULL;
              end
            end
            CMD_TICK: ctl.tick = 1'b1;
            CMD_DELETE: begin
              oslot_nxt = in_ch.slot_to_delete;
              if (XW'(in_ch.slot_to_delete) < XW'(count_r)) begin
                ctl.shift = 1'b1; shift_pt = CW'(in_ch.slot_to_delete);
                count_nxt = count_r - 1'b1;
              end else begin
                ostatus_nxt = ST_NO_SLOT;
              end
            end
            default: begin
              ovalid_nxt = 1'b0; idx_nxt = '0; nfired_nxt = 4'd0; hvalid_nxt = 1'b0;
              state_nxt = S_WALK;
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk_done) begin
          // The held fire, if any, is the final transaction; otherwise nothing was due.
          if (free_out) begin
            ovalid_nxt = 1'b1; ostatus_nxt = ST_OK;
            oslot_nxt = hvalid_r ? hslot_r : 3'd0;
            ohandle_nxt = hvalid_r ? hhandle_r : 8'd0;
            ofired_nxt = hvalid_r; olast_nxt = 1'b1;
            hvalid_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end else if (head.runs != 8'd0) begin
          // A new fire pushes the held one out, which therefore is not the last.
          if (!hvalid_r || free_out) begin
            if (hvalid_r) begin
              ovalid_nxt = 1'b1; ostatus_nxt = ST_OK; oslot_nxt = hslot_r;
              ohandle_nxt = hhandle_r; ofired_nxt = 1'b1; olast_nxt = 1'b0;
            end
            hvalid_nxt = 1'b1; hslot_nxt = 3'(idx_r); hhandle_nxt = head.handle;
            nfired_nxt = nfired_r + 4'd1;
            if (head.period == 32'd0) begin
              ctl.shift = 1'b1; shift_pt = idx_r; count_nxt = count_r - 1'b1;
            end else begin
              ctl.dec_runs = 1'b1; idx_nxt = idx_r + 1'b1;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; idx_r <= '0; nfired_r <= '0; ovalid_r <= 1'b0;
      hvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; idx_r <= idx_nxt;
      nfired_r <= nfired_nxt; ovalid_r <= ovalid_nxt; hvalid_r <= hvalid_nxt;
    end
  end
  always_ff @(posedge clk) begin
    ostatus_r <= ostatus_nxt; oslot_r <= oslot_nxt; ohandle_r <= ohandle_nxt;
    ofired_r <= ofired_nxt; olast_r <= olast_nxt;
    hslot_r <= hslot_nxt; hhandle_r <= hhandle_nxt;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.status = ostatus_r;
  assign out_ch.slot_index = oslot_r;
  assign out_ch.due_handle = ohandle_r;
  assign out_ch.fired = ofired_r;
  assign out_ch.last = olast_r;

  `PTS_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(MAX_TASKS))
  `PTS_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `PTS_ASSERT_NXT(a_fire_cap, clk, rst_n, state_r == S_WALK, nfired_r <= 4'(MAX_FIRE))
  `PTS_ASSERT_IMP(a_hold_idle, clk, rst_n, state_r == S_IDLE, !hvalid_r)
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the periodic task scheduler: directed table, then random traffic.
// Depends on pts_pkg, pts_if and the periodic_task_scheduler top level.
`timescale 1ns / 100ps
module tb_top;
  import pts_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot_index;
    logic [7:0] due_handle;
    logic       fired;
    logic       last;
  } sched_result_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  task_handle;
    logic [31:0] start_delay;
    logic [31:0] repeat_period;
    logic [2:0]  slot_to_delete;
  } sched_cmd_t;

  // One row of the directed table; has_exp marks a hand-written final result.
  typedef struct {
    sched_cmd_t    cmd;
    bit            has_exp;
    sched_result_t exp;
  } dir_row_t;

  localparam int NTASK = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  periodic_task_scheduler dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the slot table.
  logic [7:0]  tbl_handle [NTASK];
  logic [31:0] tbl_delay  [NTASK];
  logic [31:0] tbl_period [NTASK];
  logic [7:0]  tbl_runs   [NTASK];
  int          tbl_count;

  sched_result_t due_results[$];
  int n_mismatch = 0;
  int n_checked = 0;
  int n_fired = 0;
  int n_sent = 0;
  bit done_sending = 1'b0;

  function automatic sched_result_t mk_result(logic [1:0] st, logic [2:0] sl,
                                              logic [7:0] h, logic f);
    sched_result_t r;
    r.status = st;
    r.slot_index = sl;
    r.due_handle = h;
    r.fired = f;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = s; i + 1 < tbl_count; i++) begin
      tbl_handle[i] = tbl_handle[i+1];
      tbl_delay[i]  = tbl_delay[i+1];
      tbl_period[i] = tbl_period[i+1];
      tbl_runs[i]   = tbl_runs[i+1];
    end
    tbl_count--;
    tbl_handle[tbl_count] = '0;
    tbl_delay[tbl_count]  = '0;
    tbl_period[tbl_count] = '0;
    tbl_runs[tbl_count]   = '0;
  endfunction

  // Applies one command to the shadow table and queues the results it produces.
  function automatic void schedule_step(sched_cmd_t c);
    sched_result_t res[$];
    int i;
    case (c.command)
      CMD_ADD: begin
        if (tbl_count < NTASK) begin
          tbl_handle[tbl_count] = c.task_handle;
          tbl_delay[tbl_count]  = c.start_delay;
          tbl_period[tbl_count] = c.repeat_period;
          tbl_runs[tbl_count]   = '0;
          res.push_back(mk_result(ST_OK, 3'(tbl_count), '0, 1'b0));
          tbl_count++;
        end else begin
          res.push_back(mk_result(ST_FULL, '0, '0, 1'b0));
        end
      end
      CMD_TICK: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_delay[i] == 0) begin
            if (tbl_runs[i] != 8'hFF) tbl_runs[i]++;
            if (tbl_period[i] != 0) tbl_delay[i] = tbl_period[i];
          end else begin
            tbl_delay[i]--;
          end
        end
        res.push_back(mk_result(ST_OK, '0, '0, 1'b0));
      end
      CMD_DISPATCH: begin
        i = 0;
        while (i < tbl_count && res.size() < MAX_FIRE) begin
          if (tbl_runs[i] > 0) begin
            res.push_back(mk_result(ST_OK, 3'(i), tbl_handle[i], 1'b1));
            tbl_runs[i]--;
            if (tbl_period[i] == 0) begin
              drop_slot(i);
              continue;
            end
          end
          i++;
        end
        if (res.size() == 0) res.push_back(mk_result(ST_OK, '0, '0, 1'b0));
      end
      default: begin
        if (c.slot_to_delete < tbl_count) begin
          drop_slot(c.slot_to_delete);
          res.push_back(mk_result(ST_OK, c.slot_to_delete, '0, 1'b0));
        end else begin
          res.push_back(mk_result(ST_NO_SLOT, c.slot_to_delete, '0, 1'b0));
        end
      end
    endcase
    res[res.size()-1].last = 1'b1;
    foreach (res[k]) due_results.push_back(res[k]);
  endfunction

  function automatic sched_cmd_t mk_cmd(logic [1:0] op, logic [7:0] h, logic [31:0] d,
                                        logic [31:0] p, logic [2:0] s);
    sched_cmd_t c;
    c.command = op;
    c.task_handle = h;
    c.start_delay = d;
    c.repeat_period = p;
    c.slot_to_delete = s;
    return c;
  endfunction

  function automatic dir_row_t row(sched_cmd_t c);
    dir_row_t r;
    r.cmd = c;
    r.has_exp = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  function automatic dir_row_t row_exp(sched_cmd_t c, sched_result_t e);
    dir_row_t r;
    r.cmd = c;
    r.has_exp = 1'b1;
    r.exp = e;
    return r;
  endfunction

  function automatic sched_result_t fin(sched_result_t r);
    r.last = 1'b1;
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.task_handle = '0;
    in_ch.start_delay = '0;
    in_ch.repeat_period = '0;
    in_ch.slot_to_delete = '0;
    out_ch.ready = 1'b0;
  end

  // Valid stays high from one transaction into the next when there is no gap.
  task automatic send_cmd(sched_cmd_t c);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    schedule_step(c);
    in_ch.valid <= 1'b1;
    in_ch.command <= c.command;
    in_ch.task_handle <= c.task_handle;
    in_ch.start_delay <= c.start_delay;
    in_ch.repeat_period <= c.repeat_period;
    in_ch.slot_to_delete <= c.slot_to_delete;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // Well-formed traffic mostly: adds with small delays, ticks, dispatches and deletes.
  function automatic sched_cmd_t random_cmd();
    int pick;
    logic [31:0] d, p;
    pick = $urandom_range(0, 99);
    d = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 4));
    p = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 3));
    if (pick < 25) return mk_cmd(CMD_ADD, 8'($urandom()), d, p, 3'($urandom()));
    if (pick < 65) return mk_cmd(CMD_TICK, 8'($urandom()), $urandom(), $urandom(),
                                 3'($urandom()));
    if (pick < 88) return mk_cmd(CMD_DISPATCH, 8'($urandom()), $urandom(), $urandom(),
                                 3'($urandom()));
    return mk_cmd(CMD_DELETE, 8'($urandom()), $urandom(), $urandom(), 3'($urandom()));
  endfunction

  initial begin
    dir_row_t table_rows[$];
    int tp;
    for (int i = 0; i < NTASK; i++) begin
      tbl_handle[i] = '0;
      tbl_delay[i] = '0;
      tbl_period[i] = '0;
      tbl_runs[i] = '0;
    end
    tbl_count = 0;

    table_rows.push_back(row_exp(mk_cmd(CMD_DELETE, '0, '0, '0, 3'd0),
                                 fin(mk_result(ST_NO_SLOT, 3'd0, '0, 1'b0))));
    table_rows.push_back(row_exp(mk_cmd(CMD_DISPATCH, '0, '0, '0, '0),
                                 fin(mk_result(ST_OK, '0, '0, 1'b0))));
    table_rows.push_back(row_exp(mk_cmd(CMD_TICK, '0, '0, '0, '0),
                                 fin(mk_result(ST_OK, '0, '0, 1'b0))));
    // One-shot task with no delay, then a maximum-value periodic task.
    table_rows.push_back(row_exp(mk_cmd(CMD_ADD, 8'hFF, 32'd0, 32'd0, 3'd7),
                                 fin(mk_result(ST_OK, 3'd0, '0, 1'b0))));
    table_rows.push_back(row_exp(mk_cmd(CMD_ADD, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0),
                                 fin(mk_result(ST_OK, 3'd1, '0, 1'b0))));
    // The one-shot task must survive a dispatch before it is due.
    table_rows.push_back(row(mk_cmd(CMD_DISPATCH, '0, '0, '0, '0)));
    for (int i = 2; i < NTASK; i++)
      table_rows.push_back(row(mk_cmd(CMD_ADD, 8'(8'hA0 + i), '0, 32'(i % 2), '0)));
    table_rows.push_back(row_exp(mk_cmd(CMD_ADD, 8'h55, 32'd1, 32'd1, '0),
                                 fin(mk_result(ST_FULL, 3'd0, '0, 1'b0))));
    table_rows.push_back(row_exp(mk_cmd(CMD_DELETE, '0, '0, '0, 3'd7),
                                 fin(mk_result(ST_OK, 3'd7, '0, 1'b0))));
    table_rows.push_back(row_exp(mk_cmd(CMD_DELETE, '0, '0, '0, 3'd7),
                                 fin(mk_result(ST_NO_SLOT, 3'd7, '0, 1'b0))));
    table_rows.push_back(row(mk_cmd(CMD_TICK, '0, '0, '0, '0)));
    table_rows.push_back(row(mk_cmd(CMD_TICK, '0, '0, '0, '0)));
    // Adjacent one-shot tasks fire after compaction without a skipped slot.
    table_rows.push_back(row(mk_cmd(CMD_DISPATCH, '0, '0, '0, '0)));
    table_rows.push_back(row(mk_cmd(CMD_DISPATCH, '0, '0, '0, '0)));
    table_rows.push_back(row(mk_cmd(CMD_DELETE, '0, '0, '0, 3'd2)));
    table_rows.push_back(row(mk_cmd(CMD_DELETE, '0, '0, '0, 3'd0)));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[k]) begin
      if (table_rows[k].has_exp) begin
        // The final result is typed in by hand; it must agree with the predictor too.
        sched_cmd_t c;
        c = table_rows[k].cmd;
        send_cmd(c);
        if (due_results[due_results.size()-1] != table_rows[k].exp) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("directed row %0d: table expects %h, predictor %h", k,
                     table_rows[k].exp, due_results[due_results.size()-1]);
        end
      end else begin
        send_cmd(table_rows[k].cmd);
      end
    end

    tp = 0;
    while (tp < 210) begin
      if (tp == 100) wait_drained();
      send_cmd(random_cmd());
      tp++;
    end
    in_ch.valid <= 1'b0;
    done_sending = 1'b1;
  end

  // Result side: random stalls, compare with the oldest expectation.
  initial begin
    int stall;
    sched_result_t got, want;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status = out_ch.status;
      got.slot_index = out_ch.slot_index;
      got.due_handle = out_ch.due_handle;
      got.fired = out_ch.fired;
      got.last = out_ch.last;
      if (due_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", got);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (got.fired) n_fired++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    wait (done_sending);
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d commands; checked %0d results, %0d of them fired tasks.",
             n_sent, n_checked, n_fired);
    if (n_mismatch == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/pts_pkg.sv
hdl/pts_if.sv
hdl/pts_cell.sv
hdl/periodic_task_scheduler.sv
tb/tb_top.sv
